@@ rtl/core/slt_pkg.sv @@
// Shared types, character codes, token kinds and keyword tables of the small language tokenizer.
package slt_pkg;

	typedef struct packed {
		logic [7:0] ch;
		logic       final_char;
	} src_t;

	typedef struct packed {
		logic [4:0]  kind;
		logic [2:0]  err_code;
		logic [15:0] start_line;
		logic [15:0] start_col;
		logic [15:0] stop_line;
		logic [15:0] stop_col;
		logic        run_end;
	} tok_t;

	// Results of one byte: how many, and the tokens in order.
	typedef struct packed {
		logic [1:0]     count;
		tok_t [1:0]     tok;
	} tok_pair_t;

	typedef struct packed {
		logic       has;
		logic [4:0] kind;
		logic [2:0] err;
	} pend_t;

	// Lexer modes.
	localparam logic [3:0] M_IDLE    = 4'd0;
	localparam logic [3:0] M_EQ      = 4'd1;
	localparam logic [3:0] M_LT      = 4'd2;
	localparam logic [3:0] M_GT      = 4'd3;
	localparam logic [3:0] M_BANG    = 4'd4;
	localparam logic [3:0] M_SLASH   = 4'd5;
	localparam logic [3:0] M_COMMENT = 4'd6;
	localparam logic [3:0] M_STRING  = 4'd7;
	localparam logic [3:0] M_INT     = 4'd8;
	localparam logic [3:0] M_FRAC    = 4'd9;
	localparam logic [3:0] M_IDENT   = 4'd10;

	// Token kinds.
	localparam logic [4:0] K_COMMA   = 5'd0;
	localparam logic [4:0] K_SEMI    = 5'd1;
	localparam logic [4:0] K_LPAREN  = 5'd2;
	localparam logic [4:0] K_RPAREN  = 5'd3;
	localparam logic [4:0] K_RBRACE  = 5'd4;
	localparam logic [4:0] K_LBRACE  = 5'd5;
	localparam logic [4:0] K_LBRACK  = 5'd6;
	localparam logic [4:0] K_RBRACK  = 5'd7;
	localparam logic [4:0] K_EQEQ    = 5'd8;
	localparam logic [4:0] K_ASSIGN  = 5'd9;
	localparam logic [4:0] K_PLUS    = 5'd10;
	localparam logic [4:0] K_MINUS   = 5'd11;
	localparam logic [4:0] K_STAR    = 5'd12;
	localparam logic [4:0] K_SLASH   = 5'd13;
	localparam logic [4:0] K_CARET   = 5'd14;
	localparam logic [4:0] K_PCT     = 5'd15;
	localparam logic [4:0] K_LE      = 5'd16;
	localparam logic [4:0] K_LT      = 5'd17;
	localparam logic [4:0] K_GE      = 5'd18;
	localparam logic [4:0] K_GT      = 5'd19;
	localparam logic [4:0] K_NE      = 5'd20;
	localparam logic [4:0] K_FLOAT   = 5'd21;
	localparam logic [4:0] K_STRING  = 5'd22;
	localparam logic [4:0] K_INT     = 5'd23;
	localparam logic [4:0] K_IF      = 5'd24;
	localparam logic [4:0] K_IDENT   = 5'd25;
	localparam logic [4:0] K_FOR     = 5'd26;
	localparam logic [4:0] K_ELSE    = 5'd27;
	localparam logic [4:0] K_WHILE   = 5'd28;
	localparam logic [4:0] K_RETURN  = 5'd29;
	localparam logic [4:0] K_ERR     = 5'd30;

	// Error codes.
	localparam logic [2:0] E_NONE    = 3'd0;
	localparam logic [2:0] E_BANG    = 3'd1;
	localparam logic [2:0] E_DOT     = 3'd2;
	localparam logic [2:0] E_STRING  = 3'd3;
	localparam logic [2:0] E_INVALID = 3'd4;

	// Character codes.
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5A;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LZ     = 8'h7A;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// Keyword progress: if 1..2, for 3..5, else 6..9, while 10..14, return 15..20.
	function automatic logic [4:0] kw_start(input logic [7:0] c);
		case (c)
			"i":     return 5'd1;
			"f":     return 5'd3;
			"e":     return 5'd6;
			"w":     return 5'd10;
			"r":     return 5'd15;
			default: return 5'd0;
		endcase
	endfunction

	function automatic logic [4:0] kw_next(input logic [4:0] p, input logic [7:0] c);
		logic [7:0] want;
		logic       live;
		live = 1'b1;
		want = 8'h00;
		case (p)
			5'd1:    want = "f";
			5'd3:    want = "o";
			5'd4:    want = "r";
			5'd6:    want = "l";
			5'd7:    want = "s";
			5'd8:    want = "e";
			5'd10:   want = "h";
			5'd11:   want = "i";
			5'd12:   want = "l";
			5'd13:   want = "e";
			5'd15:   want = "e";
			5'd16:   want = "t";
			5'd17:   want = "u";
			5'd18:   want = "r";
			5'd19:   want = "n";
			default: live = 1'b0;
		endcase
		return (live && c == want) ? p + 5'd1 : 5'd0;
	endfunction

	function automatic logic [4:0] ident_kind(input logic [4:0] p);
		case (p)
			5'd2:    return K_IF;
			5'd5:    return K_FOR;
			5'd9:    return K_ELSE;
			5'd14:   return K_WHILE;
			5'd20:   return K_RETURN;
			default: return K_IDENT;
		endcase
	endfunction

	// The token that a mode still holds back, as it is closed without a following byte.
	function automatic pend_t pending_tok(input logic [3:0] mode, input logic [4:0] p);
		pend_t r;
		r.has  = 1'b1;
		r.err  = E_NONE;
		r.kind = K_ERR;
		case (mode)
			M_EQ:     r.kind = K_ASSIGN;
			M_LT:     r.kind = K_LT;
			M_GT:     r.kind = K_GT;
			M_BANG:   r.err  = E_BANG;
			M_SLASH:  r.kind = K_SLASH;
			M_STRING: r.kind = K_STRING;
			M_INT:    r.kind = K_INT;
			M_FRAC:   r.kind = K_FLOAT;
			M_IDENT:  r.kind = ident_kind(p);
			default:  r.has  = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] two_kind(input logic [3:0] mode);
		case (mode)
			M_EQ:    return K_EQEQ;
			M_LT:    return K_LE;
			M_GT:    return K_GE;
			default: return K_NE;
		endcase
	endfunction

endpackage

@@ rtl/core/small_language_tokenizer_top.sv @@
// Top level of the small language tokenizer: input register, lexer and token queue.
//
// Source bytes arrive on the src channel, one src_data transfer per byte, with
// final_char set on the last byte of an input. Tokens leave on the tok channel,
// one transfer per token; run_end marks the last token caused by a byte, and a
// byte may cause none, one or two tokens.
// A byte is taken into an input register; from there the lexer mode
// machine decides its tokens in one pass and writes them into a four-entry
// queue, from which the tok channel offers them.
// Throughput is one byte per cycle while the receiver keeps up; the limit is
// the queue's single output port, so a byte that makes two tokens needs two
// output transfers. The input register moves on only when the queue has room
// for two tokens.
// When the receiver stalls, tokens collect in the queue and then src_ready
// drops; nothing is lost. Reset empties the queue and the input register and
// puts the lexer in its idle mode at line 1, column 1. After final_char the
// lexer returns to that same starting point by itself.
module small_language_tokenizer_top #(
	parameter int LINE_BITS = 16,
	parameter int COL_BITS  = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          src_valid,
	output logic          src_ready,
	input  slt_pkg::src_t src_data,
	output logic          tok_valid,
	input  logic          tok_ready,
	output slt_pkg::tok_t tok_data
);

	logic               valid_s1;
	slt_pkg::src_t      data_s1;
	logic               room;
	logic               go;
	slt_pkg::tok_pair_t res;

	assign go        = valid_s1 && room;
	assign src_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_ready) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && src_ready) begin
			data_s1 <= src_data;
		end
	end

	slt_lexer #(
		.LINE_BITS (LINE_BITS),
		.COL_BITS  (COL_BITS)
	) u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (go),
		.src    (data_s1),
		.res    (res)
	);

	slt_tokq u_tokq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push_en (go),
		.push    (res),
		.room    (room),
		.valid   (tok_valid),
		.ready   (tok_ready),
		.data    (tok_data)
	);

	a_load_s1: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && src_ready |=> valid_s1)
		else $error("accepted byte did not reach the input register");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !go |=> valid_s1 && $stable(data_s1))
		else $error("waiting byte changed in the input register");

	a_pair_max: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> res.count != 2'd3)
		else $error("lexer produced more than two tokens for one byte");

	a_tok_shown: assert property (@(posedge clk) disable iff (!arst_n)
		go && res.count != 2'd0 |=> tok_valid)
		else $error("token written to the queue was not offered");

endmodule

@@ rtl/core/slt_lexer.sv @@
// Lexer mode machine and position counters: turns one byte into up to two tokens.
module slt_lexer #(
	parameter int LINE_BITS = 16,
	parameter int COL_BITS  = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  slt_pkg::src_t     src,
	output slt_pkg::tok_pair_t res
);

	localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
	localparam logic [COL_BITS-1:0]  COL_ONE  = COL_BITS'(1);

	logic [3:0]           mode_q, mode;
	logic [4:0]           kp_q, kp;
	logic [LINE_BITS-1:0] tl_q, cl_q, tl, cl;
	logic [COL_BITS-1:0]  tc_q, cc_q, tc, cc;
	logic [7:0]           c;
	logic                 used;
	logic [1:0]           n;
	slt_pkg::tok_t [1:0]  toks;
	slt_pkg::pend_t       pend;

	function automatic logic [LINE_BITS-1:0] adv_line(input logic [7:0] b,
			input logic [LINE_BITS-1:0] l);
		if (b == slt_pkg::CH_NL && l != '1) begin
			return l + 1'b1;
		end
		return l;
	endfunction

	function automatic logic [COL_BITS-1:0] adv_col(input logic [7:0] b,
			input logic [COL_BITS-1:0] k);
		if (b == slt_pkg::CH_NL) begin
			return COL_ONE;
		end else if (k != '1) begin
			return k + 1'b1;
		end
		return k;
	endfunction

	function automatic logic [15:0] sat_line(input logic [LINE_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
	endfunction

	function automatic logic [15:0] sat_col(input logic [COL_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
	endfunction

	function automatic slt_pkg::tok_t make_tok(input logic [4:0] kind, input logic [2:0] err,
			input logic [LINE_BITS-1:0] sl, input logic [COL_BITS-1:0] sc,
			input logic [LINE_BITS-1:0] el, input logic [COL_BITS-1:0] ec);
		slt_pkg::tok_t t;
		t.kind       = kind;
		t.err_code   = err;
		t.start_line = sat_line(sl);
		t.start_col  = sat_col(sc);
		t.stop_line  = sat_line(el);
		t.stop_col   = sat_col(ec);
		t.run_end    = 1'b0;
		return t;
	endfunction

	function automatic logic [4:0] punct_kind(input logic [7:0] b);
		case (b)
			slt_pkg::CH_COMMA:  return slt_pkg::K_COMMA;
			slt_pkg::CH_SEMI:   return slt_pkg::K_SEMI;
			slt_pkg::CH_LPAREN: return slt_pkg::K_LPAREN;
			slt_pkg::CH_RPAREN: return slt_pkg::K_RPAREN;
			slt_pkg::CH_RBRACE: return slt_pkg::K_RBRACE;
			slt_pkg::CH_LBRACE: return slt_pkg::K_LBRACE;
			slt_pkg::CH_LBRACK: return slt_pkg::K_LBRACK;
			slt_pkg::CH_RBRACK: return slt_pkg::K_RBRACK;
			slt_pkg::CH_PLUS:   return slt_pkg::K_PLUS;
			slt_pkg::CH_MINUS:  return slt_pkg::K_MINUS;
			slt_pkg::CH_STAR:   return slt_pkg::K_STAR;
			slt_pkg::CH_CARET:  return slt_pkg::K_CARET;
			default:            return slt_pkg::K_PCT;
		endcase
	endfunction

	always_comb begin
		mode = mode_q;
		kp   = kp_q;
		tl   = tl_q;
		tc   = tc_q;
		cl   = cl_q;
		cc   = cc_q;
		c    = src.ch;
		used = 1'b1;
		n    = 2'd0;
		toks = '0;
		pend = slt_pkg::pending_tok(mode_q, kp_q);

		// First the byte is offered to the token that is already open.
		case (mode)
			slt_pkg::M_EQ, slt_pkg::M_LT, slt_pkg::M_GT, slt_pkg::M_BANG: begin
				if (c == slt_pkg::CH_EQ) begin
					cl = adv_line(c, cl);
					cc = adv_col(c, cc);
					toks[n[0]] = make_tok(slt_pkg::two_kind(mode), slt_pkg::E_NONE,
						tl, tc, cl, cc);
					n = n + 2'd1;
					mode = slt_pkg::M_IDLE;
				end else begin
					used = 1'b0;
				end
			end
			slt_pkg::M_SLASH: begin
				if (c == slt_pkg::CH_SLASH) begin
					cl = adv_line(c, cl);
					cc = adv_col(c, cc);
					mode = slt_pkg::M_COMMENT;
				end else begin
					used = 1'b0;
				end
			end
			slt_pkg::M_COMMENT: begin
				cl = adv_line(c, cl);
				cc = adv_col(c, cc);
				if (c == slt_pkg::CH_NL) begin
					mode = slt_pkg::M_IDLE;
				end
			end
			slt_pkg::M_STRING: begin
				if (c == slt_pkg::CH_QUOTE) begin
					cl = adv_line(c, cl);
					cc = adv_col(c, cc);
					toks[n[0]] = make_tok(slt_pkg::K_STRING, slt_pkg::E_NONE, tl, tc, cl, cc);
					n = n + 2'd1;
					mode = slt_pkg::M_IDLE;
				end else if (c == slt_pkg::CH_NL) begin
					// A newline inside a string gives the error and then the string itself.
					toks[n[0]] = make_tok(slt_pkg::K_ERR, slt_pkg::E_STRING, tl, tc, cl, cc);
					n = n + 2'd1;
					cl = adv_line(c, cl);
					cc = adv_col(c, cc);
					toks[n[0]] = make_tok(slt_pkg::K_STRING, slt_pkg::E_NONE, tl, tc, cl, cc);
					n = n + 2'd1;
					mode = slt_pkg::M_IDLE;
				end else begin
					cl = adv_line(c, cl);
					cc = adv_col(c, cc);
				end
			end
			slt_pkg::M_INT: begin
				if (c inside {[slt_pkg::CH_0:slt_pkg::CH_9]}) begin
					cl = adv_line(c, cl);
					cc = adv_col(c, cc);
				end else if (c == slt_pkg::CH_DOT) begin
					cl = adv_line(c, cl);
					cc = adv_col(c, cc);
					mode = slt_pkg::M_FRAC;
				end else begin
					used = 1'b0;
				end
			end
			slt_pkg::M_FRAC: begin
				if (c inside {[slt_pkg::CH_0:slt_pkg::CH_9]}) begin
					cl = adv_line(c, cl);
					cc = adv_col(c, cc);
				end else if (c == slt_pkg::CH_DOT) begin
					cl = adv_line(c, cl);
					cc = adv_col(c, cc);
					toks[n[0]] = make_tok(slt_pkg::K_ERR, slt_pkg::E_DOT, tl, tc, cl, cc);
					n = n + 2'd1;
					mode = slt_pkg::M_IDLE;
				end else begin
					used = 1'b0;
				end
			end
			slt_pkg::M_IDENT: begin
				if (c inside {[slt_pkg::CH_0:slt_pkg::CH_9], [slt_pkg::CH_LA:slt_pkg::CH_LZ],
						[slt_pkg::CH_UA:slt_pkg::CH_UZ], slt_pkg::CH_USCORE}) begin
					cl = adv_line(c, cl);
					cc = adv_col(c, cc);
					kp = slt_pkg::kw_next(kp, c);
				end else begin
					used = 1'b0;
				end
			end
			default: begin
				mode = slt_pkg::M_IDLE;
				used = 1'b0;
			end
		endcase

		// A byte the open token refuses closes that token and is then read from the idle mode.
		if (!used) begin
			if (pend.has && mode != slt_pkg::M_IDLE) begin
				toks[n[0]] = make_tok(pend.kind, pend.err, tl, tc, cl, cc);
				n = n + 2'd1;
			end
			mode = slt_pkg::M_IDLE;
			kp   = 5'd0;
			tl   = cl;
			tc   = cc;
			cl   = adv_line(c, cl);
			cc   = adv_col(c, cc);
			case (c) inside
				slt_pkg::CH_SPACE, slt_pkg::CH_NL, slt_pkg::CH_CR, slt_pkg::CH_TAB: begin
				end
				slt_pkg::CH_COMMA,  slt_pkg::CH_SEMI,   slt_pkg::CH_LPAREN, slt_pkg::CH_RPAREN,
				slt_pkg::CH_RBRACE, slt_pkg::CH_LBRACE, slt_pkg::CH_LBRACK, slt_pkg::CH_RBRACK,
				slt_pkg::CH_PLUS,   slt_pkg::CH_MINUS,  slt_pkg::CH_STAR,   slt_pkg::CH_CARET,
				slt_pkg::CH_PCT: begin
					toks[n[0]] = make_tok(punct_kind(c), slt_pkg::E_NONE, tl, tc, cl, cc);
					n = n + 2'd1;
				end
				slt_pkg::CH_EQ:    mode = slt_pkg::M_EQ;
				slt_pkg::CH_LT:    mode = slt_pkg::M_LT;
				slt_pkg::CH_GT:    mode = slt_pkg::M_GT;
				slt_pkg::CH_BANG:  mode = slt_pkg::M_BANG;
				slt_pkg::CH_SLASH: mode = slt_pkg::M_SLASH;
				slt_pkg::CH_DOT:   mode = slt_pkg::M_FRAC;
				slt_pkg::CH_QUOTE: mode = slt_pkg::M_STRING;
				[slt_pkg::CH_0:slt_pkg::CH_9]: mode = slt_pkg::M_INT;
				[slt_pkg::CH_LA:slt_pkg::CH_LZ], [slt_pkg::CH_UA:slt_pkg::CH_UZ]: begin
					mode = slt_pkg::M_IDENT;
					kp   = slt_pkg::kw_start(c);
				end
				default: begin
					toks[n[0]] = make_tok(slt_pkg::K_ERR, slt_pkg::E_INVALID, tl, tc, cl, cc);
					n = n + 2'd1;
				end
			endcase
		end

		// End of input closes whatever is still open and rewinds the positions.
		if (src.final_char) begin
			pend = slt_pkg::pending_tok(mode, kp);
			if (pend.has) begin
				toks[n[0]] = make_tok(pend.kind, pend.err, tl, tc, cl, cc);
				n = n + 2'd1;
			end
			mode = slt_pkg::M_IDLE;
			kp   = 5'd0;
			tl   = LINE_ONE;
			tc   = COL_ONE;
			cl   = LINE_ONE;
			cc   = COL_ONE;
		end

		if (n != 2'd0) begin
			toks[n[1]].run_end = 1'b1;
		end
		res.count = n;
		res.tok   = toks;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= slt_pkg::M_IDLE;
			kp_q   <= 5'd0;
			tl_q   <= LINE_ONE;
			tc_q   <= COL_ONE;
			cl_q   <= LINE_ONE;
			cc_q   <= COL_ONE;
		end else if (step) begin
			mode_q <= mode;
			kp_q   <= kp;
			tl_q   <= tl;
			tc_q   <= tc;
			cl_q   <= cl;
			cc_q   <= cc;
		end
	end

endmodule

@@ rtl/core/slt_tokq.sv @@
// Four-entry token queue that takes up to two tokens per cycle and hands out one.
module slt_tokq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_en,
	input  slt_pkg::tok_pair_t push,
	output logic               room,
	output logic               valid,
	input  logic               ready,
	output slt_pkg::tok_t      data
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] LIM = CNT_W'(DEPTH - 2);

	slt_pkg::tok_t    mem_q [DEPTH];
	logic [PTR_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] count_q;
	logic [1:0]       push_n;
	logic             pop;

	assign push_n = push_en ? push.count : 2'd0;
	assign valid  = count_q != '0;
	assign data   = mem_q[head_q];
	assign pop    = valid && ready;
	// Room for a full pair of tokens, counting the transfer leaving this cycle.
	assign room   = (count_q <= LIM) || (pop && count_q == LIM + 1'b1);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[tail_q] <= push.tok[0];
		end
		if (push_n == 2'd2) begin
			mem_q[tail_q + PTR_W'(1)] <= push.tok[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			head_q  <= head_q + PTR_W'(pop);
			tail_q  <= tail_q + PTR_W'(push_n);
			count_q <= count_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

endmodule
